FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that must hold at the same edge as its trigger.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold at the edge after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fol_pkg.sv
// Types, constants and codes shared by the frequency ordered list.
`default_nettype none

package fol_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 16;
    localparam int POS_W     = 4;
    localparam int DEPTH_DEF = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MOVED  = 2'd0,
        ST_MISS   = 2'd1,
        ST_APPEND = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_LOAD  = 2'd3
    } t_sel;

    // One table slot.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    // Per-cell control: the load choice and the broadcast entry.
    typedef struct packed {
        t_sel   sel;
        t_entry ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/fol_if.sv
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface fol_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [fol_pkg::KEY_W-1:0]  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface fol_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fol_pkg::POS_W-1:0]   position;
    logic [fol_pkg::CNT_W-1:0]   count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/frequency_ordered_list.sv
// Top level of the frequency ordered list: control, output register and the row of cells.
//
//  Channel   Direction  Handshake      Payload
//  i_req     in         valid/ready    func, key
//  o_res     out        valid/ready    status, position, count
//
// An append, a miss or a full-table append is answered from the idle state; a hit
// also passes through the move state. The idle step compares the key in every cell,
// the move step finds the new place by comparing counts in every cell and shifts the
// row by one slot. Reset clears the occupancy, the counts and the output valid at once.
// A request is taken only while the output register is free or being emptied.
`default_nettype none

module frequency_ordered_list #(
    parameter int DEPTH = fol_pkg::DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fol_in_if.sink    i_req,
    fol_out_if.source o_res
);

    `include "assert_macros.svh"

    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_MOVE = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic [OCC_W-1:0]          r_occ, n_occ;
    logic [DEPTH-1:0]          r_hit_oh, n_hit_oh;
    logic [fol_pkg::KEY_W-1:0] r_key, n_key;
    logic [fol_pkg::CNT_W-1:0] r_newc, n_newc;
    logic                      r_out_valid, n_out_valid;
    fol_pkg::t_status          r_out_status, n_out_status;
    logic [fol_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic [fol_pkg::CNT_W-1:0] r_out_count, n_out_count;

    fol_pkg::t_entry           w_entry [DEPTH];
    fol_pkg::t_cell_ctl        w_ctl   [DEPTH];
    fol_pkg::t_entry           w_ins;
    logic [DEPTH-1:0]          w_match_raw, w_le_raw, w_valid, w_app_oh, w_last_oh;
    logic [DEPTH-1:0]          w_match, w_hit_oh, w_cand, w_first_c;
    logic [DEPTH-1:0]          w_below_hit, w_prev_below_hit, w_ins_oh, w_below_ins;
    logic [fol_pkg::CNT_W-1:0] w_hit_count, w_newc;
    logic [fol_pkg::POS_W-1:0] w_ins_pos;
    logic                      w_full, w_out_free, w_in_fire, w_move_done, w_append;

    // Handshake.
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire   = i_req.valid && i_req.ready;
    assign w_move_done = (r_state == S_MOVE) && w_out_free;
    assign w_full      = (r_occ == OCC_W'(DEPTH));
    assign w_append    = w_in_fire && !i_req.func && !w_full;

    // Occupied slots, the tail slot and the free slot after it.
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            w_valid[j]  = (OCC_W'(j) < r_occ);
            w_app_oh[j] = (OCC_W'(j) == r_occ);
        end
        for (int j = 0; j < DEPTH; j++) begin
            if (j == DEPTH - 1) begin
                w_last_oh[j] = w_valid[j];
            end else begin
                w_last_oh[j] = w_valid[j] && !w_valid[j + 1];
            end
        end
    end

    // Entry broadcast to all cells: the new key while idle, the moving entry otherwise.
    always_comb begin
        if (r_state == S_IDLE) begin
            w_ins.key   = $unsigned(i_req.key);
            w_ins.count = '0;
        end else begin
            w_ins.key   = r_key;
            w_ins.count = r_newc;
        end
    end

    // First matching slot and its raised count.
    assign w_match = w_match_raw & w_valid;

    fol_first #(.DEPTH(DEPTH)) u_hit (
        .i_vec (w_match),
        .o_oh  (w_hit_oh)
    );

    always_comb begin
        w_hit_count = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (w_hit_oh[j]) begin
                w_hit_count = w_hit_count | w_entry[j].count;
            end
        end
        w_newc = (w_hit_count == fol_pkg::CNT_MAX) ? fol_pkg::CNT_MAX
                                                   : w_hit_count + 1'b1;
    end

    // Insertion point among the remaining entries; the tail if none qualifies.
    assign w_cand = w_valid & ~r_hit_oh & w_le_raw;

    fol_first #(.DEPTH(DEPTH)) u_ins (
        .i_vec (w_cand),
        .o_oh  (w_first_c)
    );

    assign w_below_hit      = r_hit_oh - DEPTH'(1);
    assign w_prev_below_hit = {w_below_hit[DEPTH-2:0], 1'b0};

    always_comb begin
        if (w_cand == '0) begin
            w_ins_oh = w_last_oh;
        end else if ((w_first_c & w_below_hit) != '0) begin
            w_ins_oh = w_first_c;
        end else begin
            // A slot past the hit sits one place lower once the hit is taken out.
            w_ins_oh = w_first_c >> 1;
        end
    end

    assign w_below_ins = w_ins_oh - DEPTH'(1);

    always_comb begin
        w_ins_pos = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (w_ins_oh[j]) begin
                w_ins_pos = w_ins_pos | fol_pkg::POS_W'(j);
            end
        end
    end

    // Per-cell load choice.
    always_comb begin
        for (int m = 0; m < DEPTH; m++) begin
            w_ctl[m].ins = w_ins;
            w_ctl[m].sel = fol_pkg::SEL_HOLD;
            if (w_append && w_app_oh[m]) begin
                w_ctl[m].sel = fol_pkg::SEL_LOAD;
            end else if (w_move_done) begin
                if (w_ins_oh[m]) begin
                    w_ctl[m].sel = fol_pkg::SEL_LOAD;
                end else if (w_below_ins[m]) begin
                    w_ctl[m].sel = w_below_hit[m] ? fol_pkg::SEL_HOLD : fol_pkg::SEL_RIGHT;
                end else begin
                    w_ctl[m].sel = w_prev_below_hit[m] ? fol_pkg::SEL_LEFT
                                                       : fol_pkg::SEL_HOLD;
                end
            end
        end
    end

    // The row of cells, each wired to its neighbours.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fol_pkg::t_entry w_left, w_right;
        if (g == 0) begin : g_head
            assign w_left = w_entry[g];
        end else begin : g_mid_l
            assign w_left = w_entry[g - 1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g + 1];
        end
        fol_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match_raw[g]),
            .o_le    (w_le_raw[g])
        );
    end

    // Sequencing and the result register.
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_hit_oh     = r_hit_oh;
        n_key        = r_key;
        n_newc       = r_newc;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (!i_req.func) begin
                        n_out_valid = 1'b1;
                        n_out_count = '0;
                        if (w_full) begin
                            n_out_status = fol_pkg::ST_FULL;
                            n_out_pos    = '0;
                        end else begin
                            n_out_status = fol_pkg::ST_APPEND;
                            n_out_pos    = fol_pkg::POS_W'(r_occ);
                            n_occ        = r_occ + 1'b1;
                        end
                    end else if (w_match != '0) begin
                        n_hit_oh = w_hit_oh;
                        n_key    = $unsigned(i_req.key);
                        n_newc   = w_newc;
                        n_state  = S_MOVE;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = fol_pkg::ST_MISS;
                        n_out_pos    = '0;
                        n_out_count  = '0;
                    end
                end
            end
            S_MOVE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = fol_pkg::ST_MOVED;
                    n_out_pos    = w_ins_pos;
                    n_out_count  = r_newc;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hit_oh     <= n_hit_oh;
        r_key        <= n_key;
        r_newc       <= n_newc;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.status   = r_out_status;
    assign o_res.position = r_out_pos;
    assign o_res.count    = r_out_count;

    // Self checks.
    `ASSERT_ALWAYS(a_occ_bound, r_occ <= OCC_W'(DEPTH), "occupancy exceeds the table depth")
    `ASSERT_IMPLIES(a_move_hit, r_state == S_MOVE,
                    $onehot(r_hit_oh) && $onehot(w_ins_oh), "move step is not one-hot")
    `ASSERT_NEXT(a_hit_moves, w_in_fire && i_req.func && (w_match != '0),
                 r_state == S_MOVE, "a located key did not start its move step")

endmodule

`default_nettype wire

FILE: hw/rtl/fol_first.sv
// Isolates the lowest set bit of a vector as a one-hot word.
`default_nettype none

module fol_first #(
    parameter int DEPTH = fol_pkg::DEPTH_DEF
) (
    input  wire logic [DEPTH-1:0] i_vec,
    output logic      [DEPTH-1:0] o_oh
);

    // Two's complement trick: x & -x keeps only the lowest one.
    assign o_oh = i_vec & (~i_vec + DEPTH'(1));

endmodule

`default_nettype wire

FILE: hw/rtl/fol_cell.sv
// One slot of the ordered table with its key compare and count compare.
`default_nettype none

module fol_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fol_pkg::t_cell_ctl i_ctl,
    input  wire fol_pkg::t_entry    i_left,
    input  wire fol_pkg::t_entry    i_right,
    output fol_pkg::t_entry         o_entry,
    output logic                    o_match,
    output logic                    o_le
);

    logic [fol_pkg::KEY_W-1:0] r_key;
    logic [fol_pkg::CNT_W-1:0] r_count;
    logic [fol_pkg::KEY_W-1:0] n_key;
    logic [fol_pkg::CNT_W-1:0] n_count;

    // Select the slot's next contents from itself, a neighbour or the broadcast entry.
    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        case (i_ctl.sel)
            fol_pkg::SEL_HOLD: begin
                n_key   = r_key;
                n_count = r_count;
            end
            fol_pkg::SEL_LEFT: begin
                n_key   = i_left.key;
                n_count = i_left.count;
            end
            fol_pkg::SEL_RIGHT: begin
                n_key   = i_right.key;
                n_count = i_right.count;
            end
            fol_pkg::SEL_LOAD: begin
                n_key   = i_ctl.ins.key;
                n_count = i_ctl.ins.count;
            end
            default: begin
                n_key   = r_key;
                n_count = r_count;
            end
        endcase
    end

    // The key is payload; the count resets to zero.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Local compares against the broadcast entry.
    assign o_match       = (r_key == i_ctl.ins.key);
    assign o_le          = (r_count <= i_ctl.ins.count);
    assign o_entry.key   = r_key;
    assign o_entry.count = r_count;

endmodule

`default_nettype wire
